FILE: design/pwm_motif_window_scanner_assert.svh
// Assertion macros for the motif window scanner.
// Included by the top level; expects clk and arst_n in scope.
`ifndef PWM_MOTIF_WINDOW_SCANNER_ASSERT_SVH
`define PWM_MOTIF_WINDOW_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define PMWS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PMWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PMWS_ASSERT_NOW(label, ante, cons, msg)
`define PMWS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/pmws_pkg.sv
// Shared types, constants and the code weight expansion for the motif scanner.
// No dependencies.
package pmws_pkg;

	localparam int MAX_COLUMNS_DEF = 32;
	localparam int CODE_COUNT      = 16;
	localparam int CODE_W          = 4;
	localparam int WEIGHT_W        = 16;
	localparam int SCORE_W         = 21;
	localparam int MLEN_W          = 6;
	localparam int COLUMN_W        = 5;
	localparam int CMD_W           = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int POS_W           = 32;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 21'sh0FFFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 21'sh100000;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 16'sh8000;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_NUC   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOTIF_LENGTH = 2'd0,
		CFG_MIN_SCORE    = 2'd1,
		CFG_MAX_SCORE    = 2'd2,
		CFG_EMPTY_WEIGHT = 2'd3
	} cfg_idx_t;

	// Minimum weight over the bases named by an IUPAC code; empty code gets w_empty.
	function automatic logic signed [WEIGHT_W-1:0] code_weight(
		input logic [CODE_W-1:0]          code,
		input logic signed [WEIGHT_W-1:0] w_a,
		input logic signed [WEIGHT_W-1:0] w_c,
		input logic signed [WEIGHT_W-1:0] w_g,
		input logic signed [WEIGHT_W-1:0] w_t,
		input logic signed [WEIGHT_W-1:0] w_empty
	);
		logic signed [WEIGHT_W-1:0] w [CODE_W];
		logic signed [WEIGHT_W-1:0] best;
		logic any;
		w[0] = w_a;
		w[1] = w_c;
		w[2] = w_g;
		w[3] = w_t;
		best = w_empty;
		any  = 1'b0;
		for (int b = 0; b < CODE_W; b++) begin
			if (code[b]) begin
				if (!any || w[b] < best) begin
					best = w[b];
				end
				any = 1'b1;
			end
		end
		return best;
	endfunction

endpackage

FILE: design/pmws_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Uses pmws_pkg for default sizes.
module pmws_ram import pmws_pkg::*; #(
	parameter int WIDTH = WEIGHT_W,
	parameter int DEPTH = MAX_COLUMNS_DEF * CODE_COUNT
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/pwm_motif_window_scanner.sv
// Motif window scanner top level: command decode, window, scoring sequencer.
// Depends on pmws_pkg, pmws_ram and pwm_motif_window_scanner_assert.svh.
// Input channel (in_valid/in_stall) takes load, nucleotide and clear requests.
// Load: once taken, ST_LOAD writes all CODE_COUNT codes of the expanded column to
// the weight RAM. Clear and command 3 finish in IDLE. A nucleotide that does not
// fill the window: no result. Otherwise the window is walked through one shared
// adder and the single weight RAM read port, one column per cycle, over a full
// turn of the window; then ST_TAIL finishes the sum, ST_SAT saturates and ST_EMIT
// compares. in_stall is high until the scanner is back in IDLE.
// The result sits in an output register (out_valid/out_stall); a new request is
// taken while it waits, and a finished result waits in EMIT until it is free.
// Config writes (cfg_valid/cfg_ready) are always taken; cfg_ready is tied high.
// Reset clears the window, counters, state and config registers; the result payload and weight RAM are not cleared.
`include "pwm_motif_window_scanner_assert.svh"
module pwm_motif_window_scanner import pmws_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic [COLUMN_W-1:0]        column,
	input  logic signed [WEIGHT_W-1:0] weight_a,
	input  logic signed [WEIGHT_W-1:0] weight_c,
	input  logic signed [WEIGHT_W-1:0] weight_g,
	input  logic signed [WEIGHT_W-1:0] weight_t,
	input  logic [CODE_W-1:0]          nucleotide,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SCORE_W-1:0]  window_score,
	output logic                       is_hit,
	output logic [POS_W-1:0]           end_position,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [SCORE_W-1:0]         cfg_data
);

	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int LEN_W  = $clog2(MAX_COLUMNS + 1);
	localparam int ADDR_W = COL_W + CODE_W;
	localparam int DEPTH  = MAX_COLUMNS * CODE_COUNT;
	localparam int ACC_W  = WEIGHT_W + $clog2(MAX_COLUMNS);
	localparam int EXT_W  = (ACC_W > SCORE_W) ? ACC_W : SCORE_W + 1;
	localparam logic [MLEN_W:0] MAX_LEN = (MLEN_W + 1)'(MAX_COLUMNS);
	localparam logic [LEN_W-1:0] FULL = LEN_W'(MAX_COLUMNS);
	localparam logic [COL_W-1:0] LAST_ROT = COL_W'(MAX_COLUMNS - 1);
	localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SCORE_MAX);
	localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SCORE_MIN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_TAIL,
		ST_SAT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [MLEN_W-1:0]          motif_length_q;
	logic signed [SCORE_W-1:0]  min_score_q;
	logic signed [SCORE_W-1:0]  max_score_q;
	logic signed [WEIGHT_W-1:0] empty_weight_q;

	logic [CODE_W-1:0]          win_q [MAX_COLUMNS];
	logic [LEN_W-1:0]           fill_q;
	logic [POS_W-1:0]           pos_q;

	logic [COL_W-1:0]           ld_col_q;
	logic [CODE_W-1:0]          code_q;
	logic signed [WEIGHT_W-1:0] wa_q, wc_q, wg_q, wt_q, we_q;

	logic [LEN_W-1:0]           rem_q;
	logic [COL_W-1:0]           rot_q;
	logic                       rd_v_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [EXT_W-1:0]    sat_q;

	logic                       out_valid_q;
	logic signed [SCORE_W-1:0]  score_q;
	logic                       hit_q;
	logic [POS_W-1:0]           end_pos_q;

	logic [MLEN_W:0]            len_ext;
	logic [LEN_W-1:0]           eff_len;
	logic [LEN_W-1:0]           fill_nx;
	logic [LEN_W-1:0]           rem_m1;
	logic                       accept;
	logic                       col_ok;
	logic                       wr_en;
	logic [ADDR_W-1:0]          wr_addr;
	logic [WEIGHT_W-1:0]        wr_data;
	logic                       rd_en;
	logic [ADDR_W-1:0]          rd_addr;
	logic [WEIGHT_W-1:0]        rd_data;
	logic signed [EXT_W-1:0]    acc_ext;

	// window length clamped to 1..MAX_COLUMNS
	always_comb begin
		if (motif_length_q == '0) begin
			len_ext = (MLEN_W + 1)'(1);
		end else if ({1'b0, motif_length_q} > MAX_LEN) begin
			len_ext = MAX_LEN;
		end else begin
			len_ext = {1'b0, motif_length_q};
		end
	end
	assign eff_len = len_ext[LEN_W-1:0];

	assign fill_nx = (fill_q == FULL) ? fill_q : fill_q + LEN_W'(1);
	assign rem_m1  = rem_q - LEN_W'(1);
	assign accept  = in_valid && !in_stall;
	assign col_ok  = (7'(column) < 7'(MAX_COLUMNS));

	assign wr_en   = (state_q == ST_LOAD);
	assign wr_addr = {ld_col_q, code_q};
	assign wr_data = code_weight(code_q, wa_q, wc_q, wg_q, wt_q, we_q);
	assign rd_en   = (state_q == ST_SCAN) && (rem_q != '0);
	assign rd_addr = {rem_m1[COL_W-1:0], win_q[MAX_COLUMNS-1]};
	assign acc_ext = EXT_W'(acc_q);

	pmws_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(DEPTH)
	) u_weight_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_length_q <= MLEN_W'(1);
			min_score_q    <= SCORE_MIN;
			max_score_q    <= SCORE_MAX;
			empty_weight_q <= WEIGHT_MIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MOTIF_LENGTH: motif_length_q <= cfg_data[MLEN_W-1:0];
				CFG_MIN_SCORE:    min_score_q    <= cfg_data;
				CFG_MAX_SCORE:    max_score_q    <= cfg_data;
				CFG_EMPTY_WEIGHT: empty_weight_q <= cfg_data[WEIGHT_W-1:0];
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < MAX_COLUMNS; i++) begin
				win_q[i] <= '0;
			end
			fill_q      <= '0;
			pos_q       <= '0;
			ld_col_q    <= '0;
			code_q      <= '0;
			rem_q       <= '0;
			rot_q       <= '0;
			rd_v_s1     <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_v_s1 <= rd_en;
			if (rd_v_s1) begin
				acc_q <= acc_q + ACC_W'($signed(rd_data));
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_t'(command))
							CMD_LOAD: begin
								if (col_ok) begin
									ld_col_q <= COL_W'(column);
									code_q   <= '0;
									wa_q     <= weight_a;
									wc_q     <= weight_c;
									wg_q     <= weight_g;
									wt_q     <= weight_t;
									we_q     <= empty_weight_q;
									state_q  <= ST_LOAD;
								end
							end
							CMD_NUC: begin
								for (int i = 0; i < MAX_COLUMNS - 1; i++) begin
									win_q[i] <= win_q[i+1];
								end
								win_q[MAX_COLUMNS-1] <= nucleotide;
								fill_q <= fill_nx;
								pos_q  <= pos_q + POS_W'(1);
								if (fill_nx >= eff_len) begin
									rem_q   <= eff_len;
									rot_q   <= '0;
									acc_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							CMD_CLEAR: begin
								for (int i = 0; i < MAX_COLUMNS; i++) begin
									win_q[i] <= '0;
								end
								fill_q <= '0;
								pos_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD: begin
					code_q <= code_q + CODE_W'(1);
					if (code_q == CODE_W'(CODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// rotate newest-first past the tap; a full turn restores the window
					for (int i = 1; i < MAX_COLUMNS; i++) begin
						win_q[i] <= win_q[i-1];
					end
					win_q[0] <= win_q[MAX_COLUMNS-1];
					if (rem_q != '0) begin
						rem_q <= rem_m1;
					end
					rot_q <= rot_q + COL_W'(1);
					if (rot_q == LAST_ROT) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SAT) begin
			if (acc_ext > SAT_HI) begin
				sat_q <= SAT_HI;
			end else if (acc_ext < SAT_LO) begin
				sat_q <= SAT_LO;
			end else begin
				sat_q <= acc_ext;
			end
		end
		if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) begin
			score_q   <= sat_q[SCORE_W-1:0];
			hit_q     <= (sat_q >= EXT_W'(min_score_q)) && (sat_q <= EXT_W'(max_score_q));
			end_pos_q <= pos_q;
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign window_score = score_q;
	assign is_hit       = hit_q;
	assign end_position = end_pos_q;

	`PMWS_ASSERT_NOW(a_emit_needs_full_window, state_q == ST_EMIT, fill_q >= eff_len, "result with short window")
	`PMWS_ASSERT_NOW(a_walk_done, state_q == ST_TAIL, rem_q == '0, "window walk ended early")
	`PMWS_ASSERT_NOW(a_no_accept_mid_sum, accept, !rd_v_s1, "request taken during scoring")
	`PMWS_ASSERT_NEXT(a_emit_sets_valid, state_q == ST_EMIT && !out_valid_q, out_valid_q, "result lost")

endmodule

FILE: dv/pwm_motif_window_scanner_checker.sv
// Scoreboard for the motif window scanner: watches the request, result and register channels,
// predicts each window score, hit flag and end position, and compares them in order.
// Depends on pmws_pkg.
module pwm_motif_window_scanner_checker import pmws_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic [COLUMN_W-1:0]        column,
	input  logic signed [WEIGHT_W-1:0] weight_a,
	input  logic signed [WEIGHT_W-1:0] weight_c,
	input  logic signed [WEIGHT_W-1:0] weight_g,
	input  logic signed [WEIGHT_W-1:0] weight_t,
	input  logic [CODE_W-1:0]          nucleotide,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SCORE_W-1:0]  window_score,
	input  logic                       is_hit,
	input  logic [POS_W-1:0]           end_position,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [SCORE_W-1:0]         cfg_data,
	output int                         mismatches,
	output int                         open_results,
	output int                         scored,
	output int                         hits
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      hit;
		logic [POS_W-1:0]          pos;
	} window_result_t;

	window_result_t             window_results_q[$];
	window_result_t             got, want;
	logic signed [WEIGHT_W-1:0] weight_tbl [MAX_COLUMNS][CODE_COUNT];
	logic signed [WEIGHT_W-1:0] base_w [CODE_W];
	logic [CODE_W-1:0]          window [MAX_COLUMNS];
	int                         fill;
	int                         span;
	int                         fails;
	int                         n_scored;
	int                         n_hits;
	logic [POS_W-1:0]           position;
	logic [MLEN_W-1:0]          motif_len;
	logic signed [SCORE_W-1:0]  min_thr, max_thr;
	logic signed [WEIGHT_W-1:0] empty_w;

	// Lowest weight among the bases a code names; the empty code takes none_w.
	function automatic logic signed [WEIGHT_W-1:0] cheapest(
		input logic [CODE_W-1:0]          code,
		input logic signed [WEIGHT_W-1:0] w [CODE_W],
		input logic signed [WEIGHT_W-1:0] none_w
	);
		int best;
		best = 32768;
		for (int b = 0; b < CODE_W; b++) begin
			if (code[b] && w[b] < best) begin
				best = w[b];
			end
		end
		return (code == '0) ? none_w : best[WEIGHT_W-1:0];
	endfunction

	function automatic window_result_t score_window(input int len);
		int total;
		window_result_t r;
		total = 0;
		for (int c = 0; c < len; c++) begin
			total += weight_tbl[c][window[MAX_COLUMNS-len+c]];
		end
		if (total > 1048575) begin
			total = 1048575;
		end
		if (total < -1048576) begin
			total = -1048576;
		end
		r.score = total[SCORE_W-1:0];
		r.hit   = (total >= min_thr) && (total <= max_thr);
		r.pos   = position;
		return r;
	endfunction

	task automatic flag(input string msg);
		fails++;
		if (fails <= 10) begin
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_results_q.delete();
			foreach (window[i]) window[i] = '0;
			fill      = 0;
			position  = '0;
			motif_len = 6'd1;
			min_thr   = SCORE_MIN;
			max_thr   = SCORE_MAX;
			empty_w   = WEIGHT_MIN;
			fails     = 0;
			n_scored  = 0;
			n_hits    = 0;
			mismatches   <= 0;
			open_results <= 0;
			scored       <= 0;
			hits         <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MOTIF_LENGTH: motif_len = cfg_data[MLEN_W-1:0];
					CFG_MIN_SCORE:    min_thr   = cfg_data;
					CFG_MAX_SCORE:    max_thr   = cfg_data;
					CFG_EMPTY_WEIGHT: empty_w   = cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				got.score = window_score;
				got.hit   = is_hit;
				got.pos   = end_position;
				n_scored++;
				if (is_hit) begin
					n_hits++;
				end
				if (window_results_q.size() == 0) begin
					flag($sformatf("unexpected result score=%0d hit=%0b pos=%0d",
						got.score, got.hit, got.pos));
				end else begin
					want = window_results_q.pop_front();
					if (got.score !== want.score || got.hit !== want.hit
							|| got.pos !== want.pos) begin
						flag($sformatf("exp score=%0d hit=%0b pos=%0d, got score=%0d hit=%0b pos=%0d",
							want.score, want.hit, want.pos, got.score, got.hit, got.pos));
					end
				end
			end

			if (in_valid && !in_stall) begin
				case (command)
					CMD_LOAD: begin
						base_w = '{weight_a, weight_c, weight_g, weight_t};
						if (column < MAX_COLUMNS) begin
							for (int k = 0; k < CODE_COUNT; k++) begin
								weight_tbl[column][k] = cheapest(k[CODE_W-1:0], base_w, empty_w);
							end
						end
					end
					CMD_NUC: begin
						for (int i = 0; i < MAX_COLUMNS - 1; i++) begin
							window[i] = window[i+1];
						end
						window[MAX_COLUMNS-1] = nucleotide;
						if (fill < MAX_COLUMNS) begin
							fill++;
						end
						position++;
						span = (motif_len == '0) ? 1
							: (motif_len > MAX_COLUMNS) ? MAX_COLUMNS : int'(motif_len);
						if (fill >= span) begin
							window_results_q.push_back(score_window(span));
						end
					end
					CMD_CLEAR: begin
						foreach (window[i]) window[i] = '0;
						fill     = 0;
						position = '0;
					end
					default: ;
				endcase
			end

			mismatches   <= fails;
			open_results <= window_results_q.size();
			scored       <= n_scored;
			hits         <= n_hits;
		end
	end

endmodule

FILE: dv/tb_pwm_motif_window_scanner.sv
// Top of the motif window scanner bench: clock, reset, request and register stimulus,
// output stall pattern and the verdict. Depends on pmws_pkg, the scanner RTL and
// pwm_motif_window_scanner_checker.
module tb_pwm_motif_window_scanner import pmws_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET   = 650;
	localparam int DRAIN_CYCLES  = MAX_COLUMNS_DEF + 32;
	localparam int CYCLE_LIMIT   = 500000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [CMD_W-1:0]           command = '0;
	logic [COLUMN_W-1:0]        column = '0;
	logic signed [WEIGHT_W-1:0] weight_a = '0;
	logic signed [WEIGHT_W-1:0] weight_c = '0;
	logic signed [WEIGHT_W-1:0] weight_g = '0;
	logic signed [WEIGHT_W-1:0] weight_t = '0;
	logic [CODE_W-1:0]          nucleotide = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SCORE_W-1:0]  window_score;
	logic                       is_hit;
	logic [POS_W-1:0]           end_position;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [SCORE_W-1:0]         cfg_data = '0;

	int mismatches, open_results, scored, hits;
	int cycle_count = 0;
	int burst_left = 0;
	int accepted = 0;
	int ignored = 0;
	int reg_writes = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int stall_hold = 0;

	pwm_motif_window_scanner u_dut (.*);
	pwm_motif_window_scanner_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// Result side backpressure: free-flowing, light, heavy and long-hold stretches.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_hold == 0) begin
					stall_hold = $urandom_range(1, 24);
				end
				stall_hold--;
				out_stall <= (stall_hold > 4);
			end
		endcase
	end

	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return WEIGHT_MIN;
			1: return 16'sh7FFF;
			2, 3, 4, 5: return WEIGHT_W'(int'($urandom_range(0, 2000)) - 1000);
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	task automatic send(
		input logic [CMD_W-1:0]           cmd,
		input logic [COLUMN_W-1:0]        col,
		input logic signed [WEIGHT_W-1:0] wa,
		input logic signed [WEIGHT_W-1:0] wc,
		input logic signed [WEIGHT_W-1:0] wg,
		input logic signed [WEIGHT_W-1:0] wt,
		input logic [CODE_W-1:0]          code
	);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 45 : 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		command    <= cmd;
		column     <= col;
		weight_a   <= wa;
		weight_c   <= wc;
		weight_g   <= wg;
		weight_t   <= wt;
		nucleotide <= code;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (cmd == CMD_UNUSED) begin
			ignored++;
		end else begin
			accepted++;
		end
	endtask

	task automatic scan(input logic [CODE_W-1:0] code);
		send(CMD_NUC, COLUMN_W'($urandom), pick_weight(), pick_weight(), pick_weight(),
			pick_weight(), code);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [SCORE_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Let every pending score come out and any silent request finish.
	task automatic quiesce();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int len, input int lo, input int hi, input int empty);
		quiesce();
		write_reg(CFG_MOTIF_LENGTH, SCORE_W'(len));
		write_reg(CFG_MIN_SCORE, SCORE_W'(lo));
		write_reg(CFG_MAX_SCORE, SCORE_W'(hi));
		write_reg(CFG_EMPTY_WEIGHT, SCORE_W'(empty));
	endtask

	initial begin
		int len, eff, lo, hi, pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every column loaded up front so no window ever reads an unwritten entry.
		send(CMD_LOAD, '0, 16'sh7FFF, WEIGHT_MIN, -16'sd1, 16'sd0, CODE_W'($urandom));
		for (int c = 1; c < MAX_COLUMNS_DEF; c++) begin
			send(CMD_LOAD, c[COLUMN_W-1:0], pick_weight(), pick_weight(), pick_weight(),
				pick_weight(), CODE_W'($urandom));
		end

		for (int n = 0; n < CODE_COUNT; n++) begin
			scan(n[CODE_W-1:0]);
		end
		send(CMD_UNUSED, COLUMN_W'($urandom), pick_weight(), pick_weight(), pick_weight(),
			pick_weight(), CODE_W'($urandom));
		send(CMD_CLEAR, COLUMN_W'($urandom), pick_weight(), pick_weight(), pick_weight(),
			pick_weight(), CODE_W'($urandom));
		scan(4'hF);

		// zero length acts as one, crossed thresholds, empty weight taken at load time
		configure(0, 5, -5, 32767);
		send(CMD_LOAD, '0, 16'sd5, 16'sd5, -16'sd5, 16'sh7FFF, '0);
		scan(4'h0);
		scan(4'h1);
		configure(1, -5, 5, -1);
		scan(4'h0);
		scan(4'h1);
		scan(4'h4);
		scan(4'h8);

		// oversize length, full window of the most negative weights
		configure(63, -1048576, -1048576, -32768);
		for (int c = 0; c < MAX_COLUMNS_DEF; c++) begin
			send(CMD_LOAD, c[COLUMN_W-1:0], WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN,
				CODE_W'($urandom));
		end
		send(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
		repeat (MAX_COLUMNS_DEF + 2) scan(CODE_W'($urandom));

		// shorter length with the window already full
		configure(3, -1048576, 1048575, 0);
		repeat (4) scan(CODE_W'($urandom));

		while (accepted < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = MAX_COLUMNS_DEF;
				2: len = $urandom_range(MAX_COLUMNS_DEF + 1, 63);
				default: len = $urandom_range(1, 8);
			endcase
			eff = (len == 0) ? 1 : (len > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : len;
			case ($urandom_range(0, 3))
				0: begin
					lo = -1048576;
					hi = 1048575;
				end
				1: begin
					lo = $urandom_range(0, 2000);
					hi = lo - 1 - int'($urandom_range(0, 2000));
				end
				2: begin
					lo = int'($urandom_range(0, eff * 4000)) - eff * 2000;
					hi = lo + int'($urandom_range(0, eff * 3000));
				end
				default: begin
					lo = int'($urandom_range(0, 2097151)) - 1048576;
					hi = int'($urandom_range(0, 2097151)) - 1048576;
				end
			endcase
			configure(len, lo, hi, int'($urandom_range(0, 65535)) - 32768);
			repeat ($urandom_range(20, 60)) begin
				pick = $urandom_range(0, 99);
				if (pick < 72) begin
					scan(CODE_W'($urandom));
				end else if (pick < 87) begin
					send(CMD_LOAD, COLUMN_W'($urandom), pick_weight(), pick_weight(),
						pick_weight(), pick_weight(), CODE_W'($urandom));
				end else if (pick < 93) begin
					send(CMD_CLEAR, COLUMN_W'($urandom), pick_weight(), pick_weight(),
						pick_weight(), pick_weight(), CODE_W'($urandom));
				end else begin
					send(CMD_UNUSED, COLUMN_W'($urandom), pick_weight(), pick_weight(),
						pick_weight(), pick_weight(), CODE_W'($urandom));
				end
			end
		end

		quiesce();
		$display("covered %0d requests plus %0d unused commands and %0d register writes",
			accepted, ignored, reg_writes);
		$display("%0d windows scored, %0d of them hits, %0d mismatches", scored, hits, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/pmws_pkg.sv
design/pmws_ram.sv
design/pwm_motif_window_scanner.sv
dv/pwm_motif_window_scanner_checker.sv
dv/tb_pwm_motif_window_scanner.sv
